### design/pid_controller_clamped_terms_assert.svh
// Assertion macros shared by the controller modules.
`ifndef PID_CONTROLLER_CLAMPED_TERMS_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_TERMS_ASSERT_SVH

// Checked on every rising edge outside reset.
`define PCT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pct assertion failed");

// Checked on every rising edge, reset included.
`define PCT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pct assertion failed");

`endif

### design/pct_pkg.sv
package pct_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int OPND_W    = DATA_W + 1;
    localparam int PROD_W    = 2 * OPND_W;
    localparam int WIDE_W    = PROD_W - FRAC_W;
    localparam int DIV_DVD_W = OPND_W + FRAC_W;
    localparam int DIV_DVS_W = DATA_W;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W);

    localparam logic signed [DATA_W-1:0] P_TERM_MAX = 32'sd6553600;
    localparam logic signed [DATA_W-1:0] P_TERM_MIN = -32'sd6553600;
    localparam logic signed [DATA_W-1:0] D_TERM_MAX = 32'sd6553600;
    localparam logic signed [DATA_W-1:0] D_TERM_MIN = -32'sd6553600;

    localparam logic signed [DATA_W-1:0] RST_GAIN_P   = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_GAIN_I   = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_GAIN_D   = 32'sd0;
    localparam logic        [DATA_W-1:0] RST_PERIOD   = 32'd65536;
    localparam logic signed [DATA_W-1:0] RST_LIMIT_HI = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] RST_LIMIT_LO = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_GAIN_P   = 3'd0,
        REG_GAIN_I   = 3'd1,
        REG_GAIN_D   = 3'd2,
        REG_PERIOD   = 3'd3,
        REG_INTEG_HI = 3'd4,
        REG_INTEG_LO = 3'd5,
        REG_OUT_HI   = 3'd6,
        REG_OUT_LO   = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_I,
        S_INTEG,
        S_MUL_P,
        S_MUL_I2,
        S_ACC_I,
        S_WAIT_DIV,
        S_MUL_D,
        S_ACC_D,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic acc_init;
        logic acc_add;
    } mac_ctrl_t;

endpackage

### design/pid_controller_clamped_terms.sv
// PID controller with clamped terms, signed Q16.16. Each error sample accepted on
// the input channel produces one drive value with a flag that is set when an
// output limit was applied. A sample's result is registered on the output
// channel once the 49-step bit-serial divider that forms the derivative term has
// finished, and the next sample is accepted the cycle after that result is
// registered. One shared 33x33 multiplier with an accumulator forms the
// integral increment and the three gain products in turn. A finished result
// waits in the output register while the next sample is processed, and it is
// only replaced after it has been taken. Registers may be written only while no
// sample is in flight.
`include "pid_controller_clamped_terms_assert.svh"

module pid_controller_clamped_terms (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [2:0]                           cfg_index,
    input  logic [pct_pkg::DATA_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [pct_pkg::DATA_W-1:0]    error_sample,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [pct_pkg::DATA_W-1:0]    drive_value,
    output logic                                 output_clamped
);

    localparam int DW = pct_pkg::DATA_W;
    localparam int WW = pct_pkg::WIDE_W;
    localparam int FW = pct_pkg::FRAC_W;
    localparam int PW = pct_pkg::PROD_W;

    // Clamp a wide signed value to 32-bit limits, testing the upper limit first.
    function automatic logic signed [DW-1:0] clamp_wide(
        input logic signed [WW-1:0] v,
        input logic signed [DW-1:0] lo,
        input logic signed [DW-1:0] hi
    );
        logic signed [WW-1:0] lo_w;
        logic signed [WW-1:0] hi_w;
        lo_w = $signed({{(WW - DW){lo[DW-1]}}, lo});
        hi_w = $signed({{(WW - DW){hi[DW-1]}}, hi});
        if (v > hi_w)
        begin
            return hi;
        end
        else if (v < lo_w)
        begin
            return lo;
        end
        return v[DW-1:0];
    endfunction

    pct_pkg::state_t state_reg;
    pct_pkg::state_t state_next;

    logic signed [DW-1:0] gain_p_reg, gain_p_next;
    logic signed [DW-1:0] gain_i_reg, gain_i_next;
    logic signed [DW-1:0] gain_d_reg, gain_d_next;
    logic        [DW-1:0] period_reg, period_next;
    logic signed [DW-1:0] integ_hi_reg, integ_hi_next;
    logic signed [DW-1:0] integ_lo_reg, integ_lo_next;
    logic signed [DW-1:0] out_hi_reg, out_hi_next;
    logic signed [DW-1:0] out_lo_reg, out_lo_next;

    logic signed [DW-1:0] integral_sum_reg, integral_sum_next;
    logic signed [DW-1:0] prev_error_reg, prev_error_next;
    logic signed [DW-1:0] error_reg, error_next;
    logic signed [DW-1:0] d_term_reg, d_term_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [DW-1:0] drive_value_reg, drive_value_next;
    logic                 output_clamped_reg, output_clamped_next;

    pct_pkg::mac_ctrl_t               mac_ctrl;
    logic signed [pct_pkg::OPND_W-1:0] mul_a;
    logic signed [pct_pkg::OPND_W-1:0] mul_b;
    logic signed [PW-1:0]              mac_prod;
    logic signed [PW-1:0]              mac_acc;

    logic                                div_start;
    logic                                div_busy;
    logic [pct_pkg::DIV_DVD_W-1:0]       div_dividend;
    logic [pct_pkg::DIV_DVD_W-1:0]       div_quot;

    logic signed [DW-1:0]  p_term;
    logic signed [WW-1:0]  integ_raw;
    logic signed [DW-1:0]  integ_clamped;
    logic signed [DW:0]    diff;
    logic                  diff_neg;
    logic [DW:0]           diff_mag;
    logic signed [WW-1:0]  d_wide;
    logic signed [DW-1:0]  d_value;
    logic signed [WW-1:0]  y_wide;
    logic signed [WW-1:0]  out_hi_w;
    logic signed [WW-1:0]  out_lo_w;
    logic signed [DW-1:0]  y_clamped;
    logic                  y_hit;

    pct_mac u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (mac_prod),
        .acc   (mac_acc)
    );

    pct_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (period_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // Term arithmetic around the shared units.
    always_comb
    begin
        if (error_reg > pct_pkg::P_TERM_MAX)
        begin
            p_term = pct_pkg::P_TERM_MAX;
        end
        else if (error_reg < pct_pkg::P_TERM_MIN)
        begin
            p_term = pct_pkg::P_TERM_MIN;
        end
        else
        begin
            p_term = error_reg;
        end

        // The product's upper bits are the floor of error times period over 2^16.
        integ_raw = $signed({{(WW - DW){integral_sum_reg[DW-1]}}, integral_sum_reg})
                    + mac_prod[PW-1:FW];
        integ_clamped = clamp_wide(integ_raw, integ_lo_reg, integ_hi_reg);

        diff     = $signed({error_reg[DW-1], error_reg})
                   - $signed({prev_error_reg[DW-1], prev_error_reg});
        diff_neg = diff[DW];
        diff_mag = diff_neg ? (DW + 1)'(-diff) : diff;
        div_dividend = {diff_mag, {FW{1'b0}}};

        // Magnitude division, sign restored afterward: truncation toward zero.
        if (diff_neg)
        begin
            d_wide = -$signed({1'b0, div_quot});
        end
        else
        begin
            d_wide = $signed({1'b0, div_quot});
        end
        if (period_reg == '0)
        begin
            if (diff_neg)
            begin
                d_value = pct_pkg::D_TERM_MIN;
            end
            else if (diff != '0)
            begin
                d_value = pct_pkg::D_TERM_MAX;
            end
            else
            begin
                d_value = '0;
            end
        end
        else
        begin
            d_value = clamp_wide(d_wide, pct_pkg::D_TERM_MIN, pct_pkg::D_TERM_MAX);
        end

        y_wide    = mac_acc[PW-1:FW];
        out_hi_w  = $signed({{(WW - DW){out_hi_reg[DW-1]}}, out_hi_reg});
        out_lo_w  = $signed({{(WW - DW){out_lo_reg[DW-1]}}, out_lo_reg});
        y_clamped = clamp_wide(y_wide, out_lo_reg, out_hi_reg);
        y_hit     = (y_wide > out_hi_w) || (y_wide < out_lo_w);
    end

    // Sequencer.
    always_comb
    begin
        state_next          = state_reg;
        mac_ctrl            = '0;
        mul_a               = '0;
        mul_b               = '0;
        div_start           = 1'b0;
        integral_sum_next   = integral_sum_reg;
        prev_error_next     = prev_error_reg;
        error_next          = error_reg;
        d_term_next         = d_term_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        drive_value_next    = drive_value_reg;
        output_clamped_next = output_clamped_reg;

        case (state_reg)
            pct_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    error_next = error_sample;
                    state_next = pct_pkg::S_MUL_I;
                end
            end
            pct_pkg::S_MUL_I:
            begin
                mac_ctrl.load = 1'b1;
                mul_a         = $signed({error_reg[DW-1], error_reg});
                mul_b         = $signed({1'b0, period_reg});
                div_start     = 1'b1;
                state_next    = pct_pkg::S_INTEG;
            end
            pct_pkg::S_INTEG:
            begin
                integral_sum_next = integ_clamped;
                state_next        = pct_pkg::S_MUL_P;
            end
            pct_pkg::S_MUL_P:
            begin
                mac_ctrl.load = 1'b1;
                mul_a         = $signed({gain_p_reg[DW-1], gain_p_reg});
                mul_b         = $signed({p_term[DW-1], p_term});
                state_next    = pct_pkg::S_MUL_I2;
            end
            pct_pkg::S_MUL_I2:
            begin
                mac_ctrl.load     = 1'b1;
                mac_ctrl.acc_init = 1'b1;
                mul_a             = $signed({gain_i_reg[DW-1], gain_i_reg});
                mul_b             = $signed({integral_sum_reg[DW-1], integral_sum_reg});
                state_next        = pct_pkg::S_ACC_I;
            end
            pct_pkg::S_ACC_I:
            begin
                mac_ctrl.acc_add = 1'b1;
                state_next       = pct_pkg::S_WAIT_DIV;
            end
            pct_pkg::S_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    d_term_next = d_value;
                    state_next  = pct_pkg::S_MUL_D;
                end
            end
            pct_pkg::S_MUL_D:
            begin
                mac_ctrl.load = 1'b1;
                mul_a         = $signed({gain_d_reg[DW-1], gain_d_reg});
                mul_b         = $signed({d_term_reg[DW-1], d_term_reg});
                state_next    = pct_pkg::S_ACC_D;
            end
            pct_pkg::S_ACC_D:
            begin
                mac_ctrl.acc_add = 1'b1;
                state_next       = pct_pkg::S_FINISH;
            end
            pct_pkg::S_FINISH:
            begin
                // Hold here until the previous result has left the output register.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next      = 1'b1;
                    drive_value_next    = y_clamped;
                    output_clamped_next = y_hit;
                    prev_error_next     = error_reg;
                    state_next          = pct_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pct_pkg::S_IDLE;
            end
        endcase
    end

    // Register writes.
    always_comb
    begin
        gain_p_next   = gain_p_reg;
        gain_i_next   = gain_i_reg;
        gain_d_next   = gain_d_reg;
        period_next   = period_reg;
        integ_hi_next = integ_hi_reg;
        integ_lo_next = integ_lo_reg;
        out_hi_next   = out_hi_reg;
        out_lo_next   = out_lo_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pct_pkg::REG_GAIN_P:   gain_p_next   = cfg_data;
                pct_pkg::REG_GAIN_I:   gain_i_next   = cfg_data;
                pct_pkg::REG_GAIN_D:   gain_d_next   = cfg_data;
                pct_pkg::REG_PERIOD:   period_next   = cfg_data;
                pct_pkg::REG_INTEG_HI: integ_hi_next = cfg_data;
                pct_pkg::REG_INTEG_LO: integ_lo_next = cfg_data;
                pct_pkg::REG_OUT_HI:   out_hi_next   = cfg_data;
                pct_pkg::REG_OUT_LO:   out_lo_next   = cfg_data;
                default:
                begin
                    gain_p_next = gain_p_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pct_pkg::S_IDLE;
            out_valid_reg    <= 1'b0;
            integral_sum_reg <= '0;
            prev_error_reg   <= '0;
            gain_p_reg       <= pct_pkg::RST_GAIN_P;
            gain_i_reg       <= pct_pkg::RST_GAIN_I;
            gain_d_reg       <= pct_pkg::RST_GAIN_D;
            period_reg       <= pct_pkg::RST_PERIOD;
            integ_hi_reg     <= pct_pkg::RST_LIMIT_HI;
            integ_lo_reg     <= pct_pkg::RST_LIMIT_LO;
            out_hi_reg       <= pct_pkg::RST_LIMIT_HI;
            out_lo_reg       <= pct_pkg::RST_LIMIT_LO;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            integral_sum_reg <= integral_sum_next;
            prev_error_reg   <= prev_error_next;
            gain_p_reg       <= gain_p_next;
            gain_i_reg       <= gain_i_next;
            gain_d_reg       <= gain_d_next;
            period_reg       <= period_next;
            integ_hi_reg     <= integ_hi_next;
            integ_lo_reg     <= integ_lo_next;
            out_hi_reg       <= out_hi_next;
            out_lo_reg       <= out_lo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        error_reg          <= error_next;
        d_term_reg         <= d_term_next;
        drive_value_reg    <= drive_value_next;
        output_clamped_reg <= output_clamped_next;
    end

    assign in_ready       = (state_reg == pct_pkg::S_IDLE);
    assign out_valid      = out_valid_reg;
    assign drive_value    = drive_value_reg;
    assign output_clamped = output_clamped_reg;

    `PCT_ASSERT_ALWAYS(a_div_start_idle, clk, div_start |-> !div_busy)
    `PCT_ASSERT(a_d_after_div, clk, rst_n, (state_reg == pct_pkg::S_MUL_D) |-> !div_busy)
    `PCT_ASSERT(a_integ_in_limits, clk, rst_n,
        ((state_reg == pct_pkg::S_MUL_P) && $past(integ_lo_reg <= integ_hi_reg))
        |-> (($past(integ_lo_reg) <= integral_sum_reg)
             && (integral_sum_reg <= $past(integ_hi_reg))))

endmodule

### design/pct_mac.sv
module pct_mac (
    input  logic                                clk,
    input  pct_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [pct_pkg::OPND_W-1:0]   mul_a,
    input  logic signed [pct_pkg::OPND_W-1:0]   mul_b,
    output logic signed [pct_pkg::PROD_W-1:0]   prod,
    output logic signed [pct_pkg::PROD_W-1:0]   acc
);

    logic signed [pct_pkg::PROD_W-1:0] prod_reg;
    logic signed [pct_pkg::PROD_W-1:0] prod_next;
    logic signed [pct_pkg::PROD_W-1:0] acc_reg;
    logic signed [pct_pkg::PROD_W-1:0] acc_next;

    always_comb
    begin
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (ctrl.load)
        begin
            prod_next = mul_a * mul_b;
        end
        if (ctrl.acc_init)
        begin
            acc_next = prod_reg;
        end
        else if (ctrl.acc_add)
        begin
            acc_next = acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

### design/pct_div.sv
`include "pid_controller_clamped_terms_assert.svh"

module pct_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [pct_pkg::DIV_DVD_W-1:0]     dividend,
    input  logic [pct_pkg::DIV_DVS_W-1:0]     divisor,
    output logic                              busy,
    output logic [pct_pkg::DIV_DVD_W-1:0]     quotient
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [pct_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [pct_pkg::DIV_CNT_W-1:0]     cnt_next;
    logic [pct_pkg::DIV_DVS_W-1:0]     rem_reg;
    logic [pct_pkg::DIV_DVS_W-1:0]     rem_next;
    logic [pct_pkg::DIV_DVD_W-1:0]     dq_reg;
    logic [pct_pkg::DIV_DVD_W-1:0]     dq_next;
    logic [pct_pkg::DIV_DVS_W-1:0]     divisor_reg;
    logic [pct_pkg::DIV_DVS_W-1:0]     divisor_next;
    logic [pct_pkg::DIV_DVS_W:0]       shifted;
    logic                              fits;

    // One restoring step per cycle: the dividend shifts out of the top of dq_reg
    // while quotient bits shift in at the bottom.
    always_comb
    begin
        shifted      = {rem_reg, dq_reg[pct_pkg::DIV_DVD_W-1]};
        fits         = (shifted >= {1'b0, divisor_reg});
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = pct_pkg::DIV_CNT_W'(pct_pkg::DIV_DVD_W - 1);
            rem_next     = '0;
            dq_next      = dividend;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = pct_pkg::DIV_DVS_W'(shifted - {1'b0, divisor_reg});
            end
            else
            begin
                rem_next = shifted[pct_pkg::DIV_DVS_W-1:0];
            end
            dq_next = {dq_reg[pct_pkg::DIV_DVD_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        divisor_reg <= divisor_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

    `PCT_ASSERT(a_div_last_step, clk, rst_n, $fell(busy_reg) |-> ($past(cnt_reg) == '0))
    `PCT_ASSERT(a_div_rem_bound, clk, rst_n, (busy_reg && (divisor_reg != '0)) |-> (rem_reg < divisor_reg))

endmodule
